>>> rtl/integer_image_rescaler_macros.svh
// Assertion macros shared by the rescaler RTL.
// Depends on nothing; included by the top level only.
`ifndef INTEGER_IMAGE_RESCALER_MACROS_SVH
`define INTEGER_IMAGE_RESCALER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/irs_pkg.sv
// Shared constants, register indexes and types of the integer image rescaler.
// Depends on nothing; used by irs_ctrl, irs_emit and the top level (irs_ram does not use it).
package irs_pkg;

  localparam int SAMPLE_W = 8;
  localparam int PIX_W    = 3 * SAMPLE_W;

  // Defaults for the top-level size parameters.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_MAX_SCALE  = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE_DOWN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;

  // Register field widths and reset values.
  localparam int LW_W = 11;
  localparam int FH_W = 13;
  localparam int SF_W = 4;
  localparam int CC_W = 2;

  localparam logic [LW_W-1:0] RST_LINE_WIDTH    = 11'd640;
  localparam logic [FH_W-1:0] RST_FRAME_HEIGHT  = 13'd480;
  localparam logic [SF_W-1:0] RST_SCALE_FACTOR  = 4'd2;
  localparam logic [CC_W-1:0] RST_CHANNEL_COUNT = 2'd3;

  // Flags of one queued job, passed from the control unit to the emitter.
  typedef struct packed {
    logic from_ram;  // pixel comes from the line store read data
    logic eor;       // last copy closes an output row
    logic eof;       // last copy closes the output frame
    logic dropped;   // pixel ignored while replay runs
  } job_ctrl_t;

endpackage

>>> rtl/irs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module irs_ram #(
  parameter  int WIDTH = 24,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/irs_ctrl.sv
// Configuration registers, frame counters and per-item decision of the rescaler.
// Depends on irs_pkg; drives the line store ports and the emitter job interface.
module irs_ctrl #(
  parameter  int MAX_WIDTH  = irs_pkg::DEF_MAX_WIDTH,
  parameter  int MAX_HEIGHT = irs_pkg::DEF_MAX_HEIGHT,
  parameter  int MAX_SCALE  = irs_pkg::DEF_MAX_SCALE,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int CW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int SW = $clog2(MAX_SCALE + 1),
  localparam int PW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [irs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [irs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_fire_i,
  input  logic                              kind_i,
  input  logic [irs_pkg::SAMPLE_W-1:0]      sample_a_i,
  input  logic [irs_pkg::SAMPLE_W-1:0]      sample_b_i,
  input  logic [irs_pkg::SAMPLE_W-1:0]      sample_c_i,
  output logic                              job_load_o,
  output irs_pkg::job_ctrl_t                job_ctrl_o,
  output logic [SW-1:0]                     job_copies_o,
  output logic [irs_pkg::PIX_W-1:0]         job_px_o,
  output logic                              ram_we_o,
  output logic [AW-1:0]                     ram_waddr_o,
  output logic [irs_pkg::PIX_W-1:0]         ram_wdata_o,
  output logic                              ram_re_o,
  output logic [AW-1:0]                     ram_raddr_o
);

  localparam int MW = (CW > HW) ? ((CW > SW) ? CW : SW) : ((HW > SW) ? HW : SW);
  localparam int XW = MW + 2;

  // Configuration registers
  logic                          mode_down_q;
  logic [irs_pkg::LW_W-1:0]      line_width_q;
  logic [irs_pkg::FH_W-1:0]      frame_height_q;
  logic [irs_pkg::SF_W-1:0]      scale_factor_q;
  logic [irs_pkg::CC_W-1:0]      channel_count_q;

  // Frame state
  logic [CW-1:0] col_q, col_d, rcol_q, rcol_d;
  logic [HW-1:0] row_q, row_d, row_next;
  logic [PW-1:0] col_ph_q, col_ph_d, row_ph_q, row_ph_d, copies_left_q, copies_left_d;
  logic          replay_q, replay_d;

  logic [CW-1:0] w;
  logic [HW-1:0] h;
  logic [SW-1:0] s;
  logic [XW-1:0] x_w, x_h, x_s;
  logic          cfg_hit;
  logic          last_col_px, last_col_rp, last_row;
  logic          keep_dn, eor_dn, eof_dn, col_ph_wrap, row_ph_wrap;
  logic [irs_pkg::PIX_W-1:0] px_in;

  // Clamp the register values into their legal ranges
  always_comb begin
    if (line_width_q == '0) begin
      w = CW'(1);
    end else if (32'(line_width_q) > MAX_WIDTH) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(line_width_q);
    end
    if (frame_height_q == '0) begin
      h = HW'(1);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(frame_height_q);
    end
    if (scale_factor_q == '0) begin
      s = SW'(1);
    end else if (32'(scale_factor_q) > MAX_SCALE) begin
      s = SW'(MAX_SCALE);
    end else begin
      s = SW'(scale_factor_q);
    end
  end

  assign x_w = XW'(w);
  assign x_h = XW'(h);
  assign x_s = XW'(s);

  // Zero the samples beyond the channel count
  assign px_in = {
    (channel_count_q == 2'd3) ? sample_c_i : '0,
    (channel_count_q >= 2'd2) ? sample_b_i : '0,
    sample_a_i
  };

  assign last_col_px = (XW'(col_q) + XW'(1)) >= x_w;
  assign last_col_rp = (XW'(rcol_q) + XW'(1)) >= x_w;
  assign last_row    = (XW'(row_q) + XW'(1)) >= x_h;
  assign row_next    = last_row ? '0 : row_q + HW'(1);

  assign keep_dn = (row_ph_q == '0) && (col_ph_q == '0) &&
                   ((XW'(col_q) + x_s) <= x_w) && ((XW'(row_q) + x_s) <= x_h);
  assign eor_dn  = (XW'(col_q) + (x_s << 1)) > x_w;
  assign eof_dn  = eor_dn && ((XW'(row_q) + (x_s << 1)) > x_h);
  assign col_ph_wrap = (XW'(col_ph_q) + XW'(1)) >= x_s;
  assign row_ph_wrap = (XW'(row_ph_q) + XW'(1)) >= x_s;

  assign cfg_hit = cfg_we_i && (cfg_index_i <= irs_pkg::CFG_CHANNEL_COUNT);

  assign ram_waddr_o = col_q[AW-1:0];
  assign ram_wdata_o = px_in;
  assign ram_raddr_o = rcol_q[AW-1:0];

  always_comb begin
    col_d         = col_q;
    rcol_d        = rcol_q;
    row_d         = row_q;
    col_ph_d      = col_ph_q;
    row_ph_d      = row_ph_q;
    copies_left_d = copies_left_q;
    replay_d      = replay_q;
    job_load_o    = 1'b0;
    job_ctrl_o    = '0;
    job_copies_o  = s;
    job_px_o      = px_in;
    ram_we_o      = 1'b0;
    ram_re_o      = 1'b0;

    if (in_fire_i) begin
      if (mode_down_q) begin
        // ticks mean nothing when shrinking
        if (!kind_i) begin
          job_load_o     = keep_dn;
          job_ctrl_o.eor = eor_dn;
          job_ctrl_o.eof = eof_dn;
          job_copies_o   = SW'(1);
          col_d          = col_q + CW'(1);
          col_ph_d       = col_ph_wrap ? '0 : col_ph_q + PW'(1);
          if (last_col_px) begin
            col_d    = '0;
            col_ph_d = '0;
            row_ph_d = (row_ph_wrap || last_row) ? '0 : row_ph_q + PW'(1);
            row_d    = row_next;
          end
        end
      end else if (replay_q) begin
        if (!kind_i) begin
          job_load_o         = 1'b1;
          job_ctrl_o.dropped = 1'b1;
          job_copies_o       = SW'(1);
          job_px_o           = '0;
        end else begin
          ram_re_o            = 1'b1;
          job_load_o          = 1'b1;
          job_ctrl_o.from_ram = 1'b1;
          job_ctrl_o.eor      = last_col_rp;
          job_ctrl_o.eof      = last_col_rp && (copies_left_q <= PW'(1)) && last_row;
          if (last_col_rp) begin
            rcol_d = '0;
            if (copies_left_q <= PW'(1)) begin
              copies_left_d = '0;
              replay_d      = 1'b0;
              row_d         = row_next;
            end else begin
              copies_left_d = copies_left_q - PW'(1);
            end
          end else begin
            rcol_d = rcol_q + CW'(1);
          end
        end
      end else if (!kind_i) begin
        ram_we_o       = 1'b1;
        job_load_o     = 1'b1;
        job_ctrl_o.eor = last_col_px;
        job_ctrl_o.eof = last_col_px && (s == SW'(1)) && last_row;
        if (last_col_px) begin
          col_d = '0;
          if (s > SW'(1)) begin
            replay_d      = 1'b1;
            copies_left_d = PW'(s - SW'(1));
            rcol_d        = '0;
          end else begin
            row_d = row_next;
          end
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end

    // a register write restarts the frame
    if (cfg_hit) begin
      col_d         = '0;
      rcol_d        = '0;
      row_d         = '0;
      col_ph_d      = '0;
      row_ph_d      = '0;
      copies_left_d = '0;
      replay_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_down_q     <= 1'b0;
      line_width_q    <= irs_pkg::RST_LINE_WIDTH;
      frame_height_q  <= irs_pkg::RST_FRAME_HEIGHT;
      scale_factor_q  <= irs_pkg::RST_SCALE_FACTOR;
      channel_count_q <= irs_pkg::RST_CHANNEL_COUNT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        irs_pkg::CFG_MODE_DOWN:     mode_down_q     <= cfg_data_i[0];
        irs_pkg::CFG_LINE_WIDTH:    line_width_q    <= cfg_data_i[irs_pkg::LW_W-1:0];
        irs_pkg::CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_data_i[irs_pkg::FH_W-1:0];
        irs_pkg::CFG_SCALE_FACTOR:  scale_factor_q  <= cfg_data_i[irs_pkg::SF_W-1:0];
        irs_pkg::CFG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[irs_pkg::CC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      rcol_q        <= '0;
      row_q         <= '0;
      col_ph_q      <= '0;
      row_ph_q      <= '0;
      copies_left_q <= '0;
      replay_q      <= 1'b0;
    end else begin
      col_q         <= col_d;
      rcol_q        <= rcol_d;
      row_q         <= row_d;
      col_ph_q      <= col_ph_d;
      row_ph_q      <= row_ph_d;
      copies_left_q <= copies_left_d;
      replay_q      <= replay_d;
    end
  end

endmodule

>>> rtl/irs_emit.sv
// Job register and output register: repeats one pixel the requested number of times.
// Depends on irs_pkg; takes pixel data from the job or from the line store read port.
module irs_emit #(
  parameter int SW = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_load_i,
  input  irs_pkg::job_ctrl_t            job_ctrl_i,
  input  logic [SW-1:0]                 job_copies_i,
  input  logic [irs_pkg::PIX_W-1:0]     job_px_i,
  input  logic [irs_pkg::PIX_W-1:0]     ram_rdata_i,
  output logic                          take_o,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [irs_pkg::PIX_W-1:0]     out_px_o,
  output logic                          end_of_row_o,
  output logic                          end_of_frame_o,
  output logic                          dropped_o,
  output logic                          last_of_run_o
);

  logic                      job_valid_q;
  irs_pkg::job_ctrl_t        job_ctrl_q;
  logic [SW-1:0]             cnt_q;
  logic [irs_pkg::PIX_W-1:0] px_q;
  logic                      emit, last_copy;

  logic                      out_valid_q;
  logic [irs_pkg::PIX_W-1:0] out_px_q;
  logic                      eor_q, eof_q, drop_q, last_q;

  assign emit      = job_valid_q && (!out_valid_q || out_ready_i);
  assign last_copy = (cnt_q == SW'(1));
  assign take_o    = !job_valid_q || (emit && last_copy);
  assign busy_o    = job_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (job_load_i) begin
      job_valid_q <= 1'b1;
    end else if (emit && last_copy) begin
      job_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load_i) begin
      job_ctrl_q <= job_ctrl_i;
      cnt_q      <= job_copies_i;
      px_q       <= job_px_i;
    end else if (emit) begin
      cnt_q <= cnt_q - SW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Line store read data holds until the next tick is taken, so read it late
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_px_q <= job_ctrl_q.from_ram ? ram_rdata_i : px_q;
      eor_q    <= job_ctrl_q.eor && last_copy;
      eof_q    <= job_ctrl_q.eof && last_copy;
      drop_q   <= job_ctrl_q.dropped;
      last_q   <= last_copy;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_px_o       = out_px_q;
  assign end_of_row_o   = eor_q;
  assign end_of_frame_o = eof_q;
  assign dropped_o      = drop_q;
  assign last_of_run_o  = last_q;

endmodule

>>> rtl/integer_image_rescaler.sv
// Top level of the nearest-neighbor integer image rescaler.
// Depends on irs_pkg, irs_ram, irs_ctrl, irs_emit and the assertion macro header.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o): one transfer per raster pixel (kind_i 0)
//    or per replay tick (kind_i 1) with samples a, b, c.
//  - Output channel (out_valid_o/out_ready_i): one transfer per result pixel,
//    with end_of_row, end_of_frame, dropped and last_of_run flags.
//  - Config channel (cfg_valid_i/cfg_ready_o): always ready; write only when idle.
//    Any write to a listed register restarts the frame; the line store keeps data.
//  - Path: an item's input transfer loads the job register; its copies then move
//    one by one into the output register, from which they leave.
//  - Throughput: the output register takes one copy per cycle while not stalled;
//    an enlarging pixel or tick is sent scale times, every other item at most once. A new item is
//    taken in the cycle its predecessor's last copy moves to the output register.
//  - Up mode writes each pixel taken outside replay into the line store; replay ticks read one entry back.
//  - Reset clears configuration to defaults and all counters; the line store is
//    left as is and needs no clearing pass.
//  - A stalled receiver holds the output register and then the job register;
//    in_ready_o drops until the pending job's last copy moves to the output register.
`include "integer_image_rescaler_macros.svh"

module integer_image_rescaler #(
  parameter  int MAX_WIDTH  = irs_pkg::DEF_MAX_WIDTH,
  parameter  int MAX_HEIGHT = irs_pkg::DEF_MAX_HEIGHT,
  parameter  int MAX_SCALE  = irs_pkg::DEF_MAX_SCALE,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int SW = $clog2(MAX_SCALE + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [irs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [irs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [irs_pkg::SAMPLE_W-1:0]  sample_a_i,
  input  logic [irs_pkg::SAMPLE_W-1:0]  sample_b_i,
  input  logic [irs_pkg::SAMPLE_W-1:0]  sample_c_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [irs_pkg::SAMPLE_W-1:0]  out_a_o,
  output logic [irs_pkg::SAMPLE_W-1:0]  out_b_o,
  output logic [irs_pkg::SAMPLE_W-1:0]  out_c_o,
  output logic                          end_of_row_o,
  output logic                          end_of_frame_o,
  output logic                          dropped_o,
  output logic                          last_of_run_o
);

  logic                      in_fire, take, job_busy;
  logic                      job_load;
  irs_pkg::job_ctrl_t        job_ctrl;
  logic [SW-1:0]             job_copies;
  logic [irs_pkg::PIX_W-1:0] job_px, out_px;
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [irs_pkg::PIX_W-1:0] ram_wdata, ram_rdata;

  // configuration must only be written while idle (the block does not enforce this), so never stall it
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = take;
  assign in_fire     = in_valid_i && take;

  irs_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_SCALE  (MAX_SCALE)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_fire_i    (in_fire),
    .kind_i       (kind_i),
    .sample_a_i   (sample_a_i),
    .sample_b_i   (sample_b_i),
    .sample_c_i   (sample_c_i),
    .job_load_o   (job_load),
    .job_ctrl_o   (job_ctrl),
    .job_copies_o (job_copies),
    .job_px_o     (job_px),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr)
  );

  // Line store: written by source pixels, read by replay ticks. A read always
  // lands at a later edge than the write of the same entry, so no bypass.
  irs_ram #(
    .WIDTH (irs_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  irs_emit #(
    .SW (SW)
  ) u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_load_i     (job_load),
    .job_ctrl_i     (job_ctrl),
    .job_copies_i   (job_copies),
    .job_px_i       (job_px),
    .ram_rdata_i    (ram_rdata),
    .take_o         (take),
    .busy_o         (job_busy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_px_o       (out_px),
    .end_of_row_o   (end_of_row_o),
    .end_of_frame_o (end_of_frame_o),
    .dropped_o      (dropped_o),
    .last_of_run_o  (last_of_run_o)
  );

  assign out_a_o = out_px[irs_pkg::SAMPLE_W-1:0];
  assign out_b_o = out_px[2*irs_pkg::SAMPLE_W-1:irs_pkg::SAMPLE_W];
  assign out_c_o = out_px[3*irs_pkg::SAMPLE_W-1:2*irs_pkg::SAMPLE_W];

  // Frame end only on the closing copy of a row
  `IRS_ASSERT_IMPLY(a_eof_closes_row, clk_i, rst_ni, out_valid_o && end_of_frame_o, end_of_row_o && last_of_run_o)
  // A dropped pixel is a single flagged result with no row marker
  `IRS_ASSERT_IMPLY(a_drop_single, clk_i, rst_ni, out_valid_o && dropped_o, last_of_run_o && !end_of_row_o && !end_of_frame_o)
  // A pending job behind a stalled output blocks new input
  `IRS_ASSERT_IMPLY(a_stall_blocks, clk_i, rst_ni, job_busy && out_valid_o && !out_ready_i, !in_ready_o)
  // Nothing accepted in a cycle leaves no new job behind
  `IRS_ASSERT_NEXT(a_no_job_without_input, clk_i, rst_ni, !job_busy && !in_fire, !job_busy)

endmodule
